>>> hdl/esfpd_pkg.sv
// Shared types, constants and helpers of the encoder speed filter and PD controller.
`default_nettype none

package esfpd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned A_W       = 33;
  localparam int unsigned G_W       = 52;
  localparam int unsigned C_W       = 36;
  localparam int unsigned PROD_W    = A_W + G_W + 1;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [19:0] TE_RESET  = 20'd10000;
  localparam logic [23:0] TAU_RESET = 24'd0;
  localparam logic [15:0] TPR_RESET = 16'd752;

  localparam logic [CFG_IDX_W-1:0] CFG_TE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TPR = 3'd4;

  typedef enum logic [2:0] {
    OP_ANGLE, OP_SPEED, OP_FILT_NEW, OP_FILT_OLD, OP_PROP, OP_DERIV
  } op_e;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DELIVER} state_e;

  typedef enum logic [2:0] {SC_IDLE, SC_MUL, SC_ROUND, SC_CHECK, SC_DIV, SC_DONE} scl_phase_e;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [31:0] speed_setpoint;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] drive_command;
    logic signed [31:0] filtered_speed;
  } out_word_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_write_t;

  typedef struct packed {
    logic load_in;
    logic start;
    logic commit;
    logic deliver;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } ctrl_sts_t;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic [G_W-1:0]        g_mag;
    logic                  g_neg;
    logic [C_W-1:0]        c;
  } scl_req_t;

  // Saturate a 36-bit signed value to the 32-bit data range.
  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/esfpd_scale.sv
// Serial unit that computes round(a*g/c) with saturation to 32 bits.
`default_nettype none

module esfpd_scale (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire esfpd_pkg::scl_req_t req_i,
  output logic                     done_o,
  output logic signed [31:0]       result_o
);

  esfpd_pkg::scl_phase_e phase_q, phase_d;
  logic [esfpd_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic [esfpd_pkg::A_W-1:0]    a_q;
  logic [esfpd_pkg::G_W-1:0]    g_q;
  logic [esfpd_pkg::C_W-1:0]    c_q;
  logic                         neg_q;
  logic [esfpd_pkg::PROD_W-1:0] acc_q;
  logic                         ovf_q;
  logic [esfpd_pkg::C_W-1:0]    rem_q;
  logic [31:0]                  lo_q;

  logic [esfpd_pkg::A_W-1:0]    a_mag;
  logic [esfpd_pkg::PROD_W-1:0] mul_next;
  logic [esfpd_pkg::C_W:0]      rem_sh;
  logic [esfpd_pkg::C_W:0]      rem_sub;
  logic                         rem_ge;
  logic [31:0]                  lim;
  logic [31:0]                  mag;

  assign a_mag = req_i.a[esfpd_pkg::A_W-1] ? (esfpd_pkg::A_W'(0) - $unsigned(req_i.a))
                                           : $unsigned(req_i.a);

  // Multiply MSB first: shift the accumulator, add g when the multiplier bit is set.
  assign mul_next = {acc_q[esfpd_pkg::PROD_W-2:0], 1'b0}
                  + {{(esfpd_pkg::PROD_W - esfpd_pkg::G_W){1'b0}},
                     (a_q[esfpd_pkg::A_W-1] ? g_q : '0)};

  assign rem_sh  = {rem_q, lo_q[31]};
  assign rem_ge  = rem_sh >= {1'b0, c_q};
  assign rem_sub = rem_sh - {1'b0, c_q};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (phase_q)
      esfpd_pkg::SC_IDLE: begin
        if (start_i) begin
          phase_d = esfpd_pkg::SC_MUL;
          cnt_d   = '0;
        end
      end
      esfpd_pkg::SC_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == esfpd_pkg::CNT_W'(esfpd_pkg::A_W - 1)) begin
          phase_d = esfpd_pkg::SC_ROUND;
        end
      end
      esfpd_pkg::SC_ROUND: phase_d = esfpd_pkg::SC_CHECK;
      esfpd_pkg::SC_CHECK: begin
        phase_d = esfpd_pkg::SC_DIV;
        cnt_d   = '0;
      end
      esfpd_pkg::SC_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == esfpd_pkg::CNT_W'(31)) begin
          phase_d = esfpd_pkg::SC_DONE;
        end
      end
      esfpd_pkg::SC_DONE: phase_d = esfpd_pkg::SC_IDLE;
      default: phase_d = esfpd_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= esfpd_pkg::SC_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      esfpd_pkg::SC_IDLE: begin
        if (start_i) begin
          a_q   <= a_mag;
          g_q   <= req_i.g_mag;
          c_q   <= req_i.c;
          neg_q <= req_i.a[esfpd_pkg::A_W-1] ^ req_i.g_neg;
          acc_q <= '0;
        end
      end
      esfpd_pkg::SC_MUL: begin
        acc_q <= mul_next;
        a_q   <= {a_q[esfpd_pkg::A_W-2:0], 1'b0};
      end
      esfpd_pkg::SC_ROUND: begin
        acc_q <= acc_q + {{(esfpd_pkg::PROD_W - esfpd_pkg::C_W){1'b0}}, c_q >> 1};
      end
      esfpd_pkg::SC_CHECK: begin
        // A quotient of 2^32 or more saturates whatever its sign.
        ovf_q <= acc_q[esfpd_pkg::PROD_W-1:32]
                 >= {{(esfpd_pkg::PROD_W - 32 - esfpd_pkg::C_W){1'b0}}, c_q};
        rem_q <= acc_q[esfpd_pkg::C_W+31:32];
        lo_q  <= acc_q[31:0];
      end
      esfpd_pkg::SC_DIV: begin
        rem_q <= rem_ge ? rem_sub[esfpd_pkg::C_W-1:0] : rem_sh[esfpd_pkg::C_W-1:0];
        lo_q  <= {lo_q[30:0], rem_ge};
      end
      default: ;
    endcase
  end

  assign lim      = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mag      = (ovf_q || (lo_q > lim)) ? lim : lo_q;
  assign result_o = neg_q ? $signed(32'd0 - mag) : $signed(mag);
  assign done_o   = phase_q == esfpd_pkg::SC_DONE;

endmodule

`default_nettype wire

>>> hdl/esfpd_datapath.sv
// Datapath: configuration, filter state, operand selection and the scale unit.
`default_nettype none

module esfpd_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire esfpd_pkg::cfg_write_t cfg_i,
  input  wire esfpd_pkg::in_word_t   in_data_i,
  input  wire esfpd_pkg::ctrl_cmd_t  cmd_i,
  output esfpd_pkg::ctrl_sts_t       sts_o,
  output esfpd_pkg::out_word_t       out_data_o
);

  logic [19:0]        te_q;
  logic [23:0]        tau_q;
  logic signed [31:0] kp_q;
  logic signed [31:0] kd_q;
  logic [15:0]        tpr_q;
  logic [esfpd_pkg::G_W-1:0] kd_scaled_q;

  logic signed [31:0] last_angle_q;
  logic signed [31:0] last_wf_q;
  logic signed [31:0] last_err_q;

  logic signed [esfpd_pkg::A_W-1:0] sum_q;
  logic signed [31:0] sp_q, theta_q, w_q, t1_q, wf_q, err_q, p_q, cmd_q;
  esfpd_pkg::out_word_t out_q;

  logic [31:0] kp_mag, kd_mag;
  logic [19:0] te_eff;
  logic [15:0] tpr_eff;
  logic [24:0] te_tau;
  esfpd_pkg::scl_req_t req;
  logic               scl_done;
  logic signed [31:0] r;
  logic signed [31:0] wf_calc, err_calc, cmd_calc;

  assign kp_mag  = kp_q[31] ? (32'd0 - $unsigned(kp_q)) : $unsigned(kp_q);
  assign kd_mag  = kd_q[31] ? (32'd0 - $unsigned(kd_q)) : $unsigned(kd_q);
  assign te_eff  = (te_q == 20'd0) ? 20'd1 : te_q;
  assign tpr_eff = (tpr_q == 16'd0) ? 16'd1 : tpr_q;
  assign te_tau  = {5'd0, te_eff} + {1'b0, tau_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q  <= esfpd_pkg::TE_RESET;
      tau_q <= esfpd_pkg::TAU_RESET;
      kp_q  <= '0;
      kd_q  <= '0;
      tpr_q <= esfpd_pkg::TPR_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        esfpd_pkg::CFG_TE:  te_q  <= cfg_i.data[19:0];
        esfpd_pkg::CFG_TAU: tau_q <= cfg_i.data[23:0];
        esfpd_pkg::CFG_KP:  kp_q  <= $signed(cfg_i.data);
        esfpd_pkg::CFG_KD:  kd_q  <= $signed(cfg_i.data);
        esfpd_pkg::CFG_TPR: tpr_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // |Kd| times one million, refreshed every cycle; the user must keep configuration static while busy (unenforced).
  always_ff @(posedge clk_i) begin
    kd_scaled_q <= kd_mag * esfpd_pkg::US_PER_S;
  end

  always_comb begin
    req = '0;
    unique case (cmd_i.op)
      esfpd_pkg::OP_ANGLE: begin
        req.a     = sum_q;
        req.g_mag = {20'd0, esfpd_pkg::PI_Q30};
        req.c     = {6'd0, tpr_eff, 14'd0};
      end
      esfpd_pkg::OP_SPEED: begin
        req.a     = 33'(theta_q) - 33'(last_angle_q);
        req.g_mag = {32'd0, esfpd_pkg::US_PER_S};
        req.c     = {16'd0, te_eff};
      end
      esfpd_pkg::OP_FILT_NEW: begin
        req.a     = 33'(w_q);
        req.g_mag = {32'd0, te_eff};
        req.c     = {11'd0, te_tau};
      end
      esfpd_pkg::OP_FILT_OLD: begin
        req.a     = 33'(last_wf_q);
        req.g_mag = {28'd0, tau_q};
        req.c     = {11'd0, te_tau};
      end
      esfpd_pkg::OP_PROP: begin
        req.a     = 33'(err_q);
        req.g_mag = {20'd0, kp_mag};
        req.g_neg = kp_q[31];
        req.c     = {19'd0, 1'b1, 16'd0};
      end
      esfpd_pkg::OP_DERIV: begin
        req.a     = 33'(err_q) - 33'(last_err_q);
        req.g_mag = kd_scaled_q;
        req.g_neg = kd_q[31];
        req.c     = {te_eff, 16'd0};
      end
      default: req = '0;
    endcase
  end

  esfpd_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .req_i    (req),
    .done_o   (scl_done),
    .result_o (r)
  );

  assign wf_calc  = esfpd_pkg::sat36(36'(t1_q) + 36'(r));
  assign err_calc = esfpd_pkg::sat36(36'(sp_q) - 36'(wf_calc));
  assign cmd_calc = esfpd_pkg::sat36(-36'(p_q) - 36'(r));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle_q <= '0;
      last_wf_q    <= '0;
      last_err_q   <= '0;
    end else if (cmd_i.commit) begin
      case (cmd_i.op)
        esfpd_pkg::OP_SPEED:    last_angle_q <= theta_q;
        esfpd_pkg::OP_FILT_OLD: last_wf_q    <= wf_calc;
        esfpd_pkg::OP_DERIV:    last_err_q   <= err_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sum_q <= 33'(in_data_i.right_count) + 33'(in_data_i.left_count);
      sp_q  <= in_data_i.speed_setpoint;
    end
    if (cmd_i.commit) begin
      case (cmd_i.op)
        esfpd_pkg::OP_ANGLE:    theta_q <= r;
        esfpd_pkg::OP_SPEED:    w_q     <= r;
        esfpd_pkg::OP_FILT_NEW: t1_q    <= r;
        esfpd_pkg::OP_FILT_OLD: begin
          wf_q  <= wf_calc;
          err_q <= err_calc;
        end
        esfpd_pkg::OP_PROP:     p_q     <= r;
        esfpd_pkg::OP_DERIV:    cmd_q   <= cmd_calc;
        default: ;
      endcase
    end
    if (cmd_i.deliver) begin
      out_q.drive_command  <= cmd_q;
      out_q.filtered_speed <= wf_q;
    end
  end

  assign sts_o.done = scl_done;
  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> hdl/esfpd_ctrl.sv
// Controller: sequences the six scale operations of one word and the output handoff.
`default_nettype none

module esfpd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire esfpd_pkg::ctrl_sts_t sts_i,
  output esfpd_pkg::ctrl_cmd_t      cmd_o
);

  esfpd_pkg::state_e state_q, state_d;
  esfpd_pkg::op_e    step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              in_fire;

  assign in_ready_o  = state_q == esfpd_pkg::ST_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.op      = step_q;
    unique case (state_q)
      esfpd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = esfpd_pkg::OP_ANGLE;
          state_d       = esfpd_pkg::ST_ISSUE;
        end
      end
      esfpd_pkg::ST_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = esfpd_pkg::ST_WAIT;
      end
      esfpd_pkg::ST_WAIT: begin
        if (sts_i.done) begin
          cmd_o.commit = 1'b1;
          state_d      = esfpd_pkg::ST_ISSUE;
          unique case (step_q)
            esfpd_pkg::OP_ANGLE:    step_d = esfpd_pkg::OP_SPEED;
            esfpd_pkg::OP_SPEED:    step_d = esfpd_pkg::OP_FILT_NEW;
            esfpd_pkg::OP_FILT_NEW: step_d = esfpd_pkg::OP_FILT_OLD;
            esfpd_pkg::OP_FILT_OLD: step_d = esfpd_pkg::OP_PROP;
            esfpd_pkg::OP_PROP:     step_d = esfpd_pkg::OP_DERIV;
            esfpd_pkg::OP_DERIV:    state_d = esfpd_pkg::ST_DELIVER;
            default:                state_d = esfpd_pkg::ST_IDLE;
          endcase
        end
      end
      esfpd_pkg::ST_DELIVER: begin
        // The output register takes the word once the previous one is gone.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.deliver = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = esfpd_pkg::ST_IDLE;
        end
      end
      default: state_d = esfpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esfpd_pkg::ST_IDLE;
      step_q      <= esfpd_pkg::OP_ANGLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> state_q == esfpd_pkg::ST_WAIT)
    else $error("scale unit finished outside the wait state");

  a_accept_starts_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == esfpd_pkg::ST_ISSUE && step_q == esfpd_pkg::OP_ANGLE))
    else $error("accepted word did not start with the angle step");

  a_deliver_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == esfpd_pkg::ST_DELIVER && out_valid_q && !out_ready_i)
    |=> state_q == esfpd_pkg::ST_DELIVER)
    else $error("result overwrote a word still waiting at the output");

  a_commit_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.done)
    else $error("commit without a finished scale result");

endmodule

`default_nettype wire

>>> hdl/encoder_speed_filter_pd_core.sv
// Top level of the encoder speed filter and PD speed controller.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one word per sample period with
// both wheel counts and the speed setpoint. Output channel (out_valid_o/out_ready_i/
// out_data_o): one word per input with the PD drive command and the filtered speed.
// Configuration channel (cfg_valid_i/cfg_ready_o): register index and data; always
// ready. The user must see that it is written only while no word is in flight; the
// block leaves that unenforced. Indexes past the list are ignored. Each word runs
// six scale operations on one shared serial unit: an issue cycle, a shift-add
// multiply, a round step, a range check, a restoring divide and a done cycle. The
// next word can be accepted in the cycle after the handoff to the output register,
// and no new word is taken while one is still in flight.
// The output register holds a finished word while the receiver stalls; the next
// input is still accepted and computed, and only its handoff waits for the output.
// Reset loads the default configuration and clears the filter and error history.
`default_nettype none

module encoder_speed_filter_pd_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire esfpd_pkg::in_word_t                   in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output esfpd_pkg::out_word_t                       out_data_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [esfpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [31:0]                           cfg_data_i
);

  esfpd_pkg::ctrl_cmd_t  cmd;
  esfpd_pkg::ctrl_sts_t  sts;
  esfpd_pkg::cfg_write_t cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  esfpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esfpd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
